// ===== rtl/path_carrot_selector_assert.svh =====
// ---------------------------------------------------------------------------
// Path carrot selector assertion macros
// Concurrent assertion helpers shared by the path carrot selector RTL.
// ---------------------------------------------------------------------------
`ifndef PATH_CARROT_SELECTOR_ASSERT_SVH
`define PATH_CARROT_SELECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PCS_ASSERT_IMPL(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("path carrot selector assertion failed");

`define PCS_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("path carrot selector assertion failed");

`else

`define PCS_ASSERT_IMPL(label, clock, resetn, ante, cons)

`define PCS_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

// ===== rtl/pcs_pkg.sv =====
// ---------------------------------------------------------------------------
// Path carrot selector package
// Widths, codes and shared types of the path carrot selector.
// ---------------------------------------------------------------------------
package pcs_pkg;

    localparam int COORD_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int ROOT_W     = COORD_BITS + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int MUL_W      = (ROOT_W > CFG_W) ? ROOT_W : CFG_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int EXC_W      = ROOT_W + 2;
    localparam int BEND_SHIFT = 15;
    localparam int RUN_W      = 24;
    localparam int CNT_W      = $clog2(ROOT_W);
    localparam int SEEN_W     = 2;
    localparam int CAUSE_W    = 3;

    localparam logic [RUN_W-1:0] RUN_MAX            = {RUN_W{1'b1}};
    localparam logic [CFG_W-1:0] CARROT_DIST_RESET  = CFG_W'(400);
    localparam logic [CFG_W-1:0] BEND_FACTOR_RESET  = CFG_W'(23170);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARROT_DISTANCE = 1'b0,
        CFG_BEND_FACTOR     = 1'b1
    } cfg_index_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_EMPTY = 3'd0,
        CAUSE_SHORT = 3'd1,
        CAUSE_DIST  = 3'd2,
        CAUSE_BEND  = 3'd3,
        CAUSE_END   = 3'd4
    } cause_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

// ===== rtl/pcs_isqrt.sv =====
// ---------------------------------------------------------------------------
// Path carrot selector integer square root
// Bit-serial restoring square root, one result bit per clock cycle.
// ---------------------------------------------------------------------------
module pcs_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pcs_pkg::RAD_W-1:0]    radicand,
    output pcs_pkg::sqrt_status_t        status,
    output logic [pcs_pkg::ROOT_W-1:0]   root
);
    import pcs_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [RAD_W-1:0]  rad_next;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W+1:0] rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    logic [ROOT_W+3:0] trial_num;
    logic [ROOT_W+3:0] trial_sub;
    logic [ROOT_W+3:0] trial_diff;
    logic              trial_ge;

    assign trial_num  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial_sub  = {2'b00, root_reg, 2'b01};
    assign trial_diff = trial_num - trial_sub;
    assign trial_ge   = (trial_num >= trial_sub);

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = trial_ge ? trial_diff[ROOT_W+1:0] : trial_num[ROOT_W+1:0];
            root_next = {root_reg[ROOT_W-2:0], trial_ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

// ===== rtl/path_carrot_selector.sv =====
// ---------------------------------------------------------------------------
// Path carrot selector
// Picks a subtarget on a planned path from a stream of path points.
// ---------------------------------------------------------------------------
// Points enter on the input channel (in_valid, in_stall) one transaction at a
// time; last_point closes a path and empty_marker reports an empty path.
// The selected point leaves on the output channel (out_valid, out_stall) as
// one transaction per closed path. The user writes configuration through
// cfg_we, cfg_index and cfg_data while the block is idle; it is not enforced.
// The first two points of a path need no arithmetic. Each later point uses
// a shared 17 x 17 multiplier and a bit-serial square root that resolves one
// result bit per cycle: one root for the third point, two roots and a bend
// test for every later point until a stop decision is made, one after that.
// The closing transaction loads the output register in a separate emit state.
// in_stall is high while a point is being processed. The output register
// holds a result while out_stall is high, and the block keeps taking points
// meanwhile; only a new result waits for the register to drain.
// Reset clears the path state, empties the output register and sets the
// carrot distance to 400 mm and the bend factor to 23170.
// ---------------------------------------------------------------------------
`include "path_carrot_selector_assert.svh"

module path_carrot_selector (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pcs_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [pcs_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [pcs_pkg::COORD_BITS-1:0] point_y,
    input  logic                                  last_point,
    input  logic                                  empty_marker,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pcs_pkg::COORD_BITS-1:0] carrot_x,
    output logic signed [pcs_pkg::COORD_BITS-1:0] carrot_y,
    output logic [pcs_pkg::CAUSE_W-1:0]           stop_cause
);
    import pcs_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQX    = 8'b0000_0010,
        ST_SQY    = 8'b0000_0100,
        ST_SUM    = 8'b0000_1000,
        ST_ROOT   = 8'b0001_0000,
        ST_BEND   = 8'b0010_0000,
        ST_DECIDE = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t                  state_reg;

    logic [CFG_W-1:0]        carrot_reg;
    logic [CFG_W-1:0]        bend_reg;

    logic signed [COORD_BITS-1:0] older_x_reg;
    logic signed [COORD_BITS-1:0] older_y_reg;
    logic signed [COORD_BITS-1:0] newer_x_reg;
    logic signed [COORD_BITS-1:0] newer_y_reg;
    logic signed [COORD_BITS-1:0] chosen_x_reg;
    logic signed [COORD_BITS-1:0] chosen_y_reg;
    logic [SEEN_W-1:0]       seen_reg;
    logic [ROOT_W-1:0]       last_seg_reg;
    logic [RUN_W-1:0]        run_reg;
    logic                    choice_reg;
    cause_t                  cause_reg;

    logic signed [COORD_BITS-1:0] pt_x_reg;
    logic signed [COORD_BITS-1:0] pt_y_reg;
    logic                    last_reg;
    logic                    empty_reg;
    logic                    short_reg;
    logic                    pass_reg;
    logic [ROOT_W-1:0]       d1d2_reg;
    logic [ROOT_W-1:0]       d0d2_reg;
    logic [PROD_W-1:0]       sqx_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic                    out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    cause_t                  out_cause_reg;

    logic                    in_accept;
    logic                    out_free;
    logic signed [COORD_BITS-1:0] opa_x;
    logic signed [COORD_BITS-1:0] opa_y;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]       neg_dx;
    logic [DIFF_W-1:0]       neg_dy;
    logic [COORD_BITS-1:0]   mag_x;
    logic [COORD_BITS-1:0]   mag_y;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [PROD_W-1:0]       prod;
    logic [SQ_W:0]           sq_sum;
    logic                    sqrt_start;
    logic [RAD_W-1:0]        sqrt_radicand;
    sqrt_status_t            sq_status;
    logic [ROOT_W-1:0]       sqrt_root;
    logic signed [EXC_W-1:0] excess;
    logic [EXC_W-1:0]        neg_excess;
    logic [ROOT_W:0]         excess_mag;
    logic [PROD_W-1:0]       bend_lhs;
    logic                    bend_hit;
    logic [RUN_W:0]          run_sum;
    logic [RUN_W-1:0]        run_new;
    logic                    dist_hit;
    logic                    emit_fire;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign emit_fire  = (state_reg == ST_EMIT) && out_free;

    assign opa_x  = pass_reg ? older_x_reg : newer_x_reg;
    assign opa_y  = pass_reg ? older_y_reg : newer_y_reg;
    assign dx     = DIFF_W'(pt_x_reg) - DIFF_W'(opa_x);
    assign dy     = DIFF_W'(pt_y_reg) - DIFF_W'(opa_y);
    assign neg_dx = -dx;
    assign neg_dy = -dy;
    assign mag_x  = dx[DIFF_W-1] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign mag_y  = dy[DIFF_W-1] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    always_comb
    begin
        case (state_reg)
            ST_SQY:
            begin
                mul_a = MUL_W'(mag_y);
                mul_b = MUL_W'(mag_y);
            end
            ST_BEND:
            begin
                mul_a = MUL_W'(last_seg_reg);
                mul_b = MUL_W'(bend_reg);
            end
            default:
            begin
                mul_a = MUL_W'(mag_x);
                mul_b = MUL_W'(mag_x);
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign sq_sum        = {1'b0, sqx_reg[SQ_W-1:0]} + {1'b0, prod_reg[SQ_W-1:0]};
    assign sqrt_radicand = RAD_W'(sq_sum);
    assign sqrt_start    = (state_reg == ST_SUM);

    pcs_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .status   (sq_status),
        .root     (sqrt_root)
    );

    assign excess     = EXC_W'(d1d2_reg) + EXC_W'(last_seg_reg) - EXC_W'(d0d2_reg);
    assign neg_excess = -excess;
    assign excess_mag = excess[EXC_W-1] ? neg_excess[ROOT_W:0] : excess[ROOT_W:0];
    assign bend_lhs   = PROD_W'({excess_mag, {BEND_SHIFT{1'b0}}});
    assign bend_hit   = (bend_lhs > prod_reg);

    assign run_sum  = {1'b0, run_reg} + (RUN_W + 1)'(last_seg_reg);
    assign run_new  = run_sum[RUN_W] ? RUN_MAX : run_sum[RUN_W-1:0];
    assign dist_hit = (run_new > RUN_W'(carrot_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrot_reg <= CARROT_DIST_RESET;
            bend_reg   <= BEND_FACTOR_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BEND_FACTOR)
            begin
                bend_reg <= cfg_data;
            end
            else
            begin
                carrot_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            older_x_reg   <= '0;
            older_y_reg   <= '0;
            newer_x_reg   <= '0;
            newer_y_reg   <= '0;
            chosen_x_reg  <= '0;
            chosen_y_reg  <= '0;
            seen_reg      <= '0;
            last_seg_reg  <= '0;
            run_reg       <= '0;
            choice_reg    <= 1'b0;
            cause_reg     <= CAUSE_EMPTY;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    pass_reg <= 1'b0;
                    if (in_accept)
                    begin
                        if (empty_marker)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else if (seen_reg == 2'd0)
                        begin
                            seen_reg  <= 2'd1;
                            state_reg <= last_point ? ST_EMIT : ST_IDLE;
                        end
                        else if (seen_reg == 2'd1)
                        begin
                            newer_x_reg <= point_x;
                            newer_y_reg <= point_y;
                            seen_reg    <= 2'd2;
                            state_reg   <= last_point ? ST_EMIT : ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SQX;
                        end
                    end
                end
                ST_SQX:
                begin
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (sq_status.done)
                    begin
                        if (pass_reg)
                        begin
                            state_reg <= ST_BEND;
                        end
                        else if (seen_reg == 2'd3 && !choice_reg)
                        begin
                            pass_reg  <= 1'b1;
                            state_reg <= ST_SQX;
                        end
                        else
                        begin
                            last_seg_reg <= sqrt_root;
                            older_x_reg  <= newer_x_reg;
                            older_y_reg  <= newer_y_reg;
                            newer_x_reg  <= pt_x_reg;
                            newer_y_reg  <= pt_y_reg;
                            seen_reg     <= 2'd3;
                            state_reg    <= last_reg ? ST_EMIT : ST_IDLE;
                        end
                    end
                end
                ST_BEND:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    run_reg <= run_new;
                    if (dist_hit)
                    begin
                        choice_reg   <= 1'b1;
                        cause_reg    <= CAUSE_DIST;
                        chosen_x_reg <= newer_x_reg;
                        chosen_y_reg <= newer_y_reg;
                    end
                    else if (bend_hit)
                    begin
                        choice_reg   <= 1'b1;
                        cause_reg    <= CAUSE_BEND;
                        chosen_x_reg <= newer_x_reg;
                        chosen_y_reg <= newer_y_reg;
                    end
                    last_seg_reg <= d1d2_reg;
                    older_x_reg  <= newer_x_reg;
                    older_y_reg  <= newer_y_reg;
                    newer_x_reg  <= pt_x_reg;
                    newer_y_reg  <= pt_y_reg;
                    state_reg    <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        older_x_reg   <= '0;
                        older_y_reg   <= '0;
                        newer_x_reg   <= '0;
                        newer_y_reg   <= '0;
                        chosen_x_reg  <= '0;
                        chosen_y_reg  <= '0;
                        seen_reg      <= '0;
                        last_seg_reg  <= '0;
                        run_reg       <= '0;
                        choice_reg    <= 1'b0;
                        cause_reg     <= CAUSE_EMPTY;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pt_x_reg  <= point_x;
            pt_y_reg  <= point_y;
            last_reg  <= last_point;
            empty_reg <= empty_marker;
            short_reg <= (seen_reg != 2'd3);
        end
        if (state_reg == ST_SQX)
        begin
            sqx_reg <= prod;
        end
        if (state_reg == ST_SQY || state_reg == ST_BEND)
        begin
            prod_reg <= prod;
        end
        if (state_reg == ST_ROOT && sq_status.done)
        begin
            if (pass_reg)
            begin
                d0d2_reg <= sqrt_root;
            end
            else
            begin
                d1d2_reg <= sqrt_root;
            end
        end
        if (emit_fire)
        begin
            if (empty_reg)
            begin
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_cause_reg <= CAUSE_EMPTY;
            end
            else if (short_reg)
            begin
                out_x_reg     <= pt_x_reg;
                out_y_reg     <= pt_y_reg;
                out_cause_reg <= CAUSE_SHORT;
            end
            else if (choice_reg)
            begin
                out_x_reg     <= chosen_x_reg;
                out_y_reg     <= chosen_y_reg;
                out_cause_reg <= cause_reg;
            end
            else
            begin
                out_x_reg     <= pt_x_reg;
                out_y_reg     <= pt_y_reg;
                out_cause_reg <= CAUSE_END;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign carrot_x   = out_x_reg;
    assign carrot_y   = out_y_reg;
    assign stop_cause = out_cause_reg;

    // The square root unit only runs while a point is being processed.
    `PCS_ASSERT_IMPL(a_idle_sqrt_quiet, clk, rst_n, state_reg == ST_IDLE, !sq_status.busy)
    `PCS_ASSERT_IMPL(a_sqrt_start_free, clk, rst_n, sqrt_start, !sq_status.busy && !sq_status.done)
    `PCS_ASSERT_IMPL(a_out_from_emit, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_EMIT))
    `PCS_ASSERT_IMPL(a_choice_cause, clk, rst_n, choice_reg, cause_reg == CAUSE_DIST || cause_reg == CAUSE_BEND)
    `PCS_ASSERT_IMPL(a_choice_full_window, clk, rst_n, choice_reg, seen_reg == 2'd3)

endmodule

// ===== tb/path_carrot_selector_tb.sv =====
// ---------------------------------------------------------------------------
// Path carrot selector testbench
// Drives planned paths point by point into the path carrot selector and
// checks every selected subtarget against a predictor that runs alongside
// the stimulus. Directed paths cover the empty path, short paths and each
// stop cause; random paths run under several carrot distance and bend
// factor settings, with bursty input, output stalls and one long output
// hold-off that backs the block up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_carrot_selector_tb;

    import pcs_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        cause_t                       cause;
    } carrot_t;

    typedef struct {
        longint old_x;
        longint old_y;
        longint mid_x;
        longint mid_y;
        int     seen;
        longint seg_len;
        longint travelled;
        bit     picked;
        longint pick_x;
        longint pick_y;
        cause_t pick_cause;
    } path_window_t;

    typedef enum {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    localparam int ITEM_TARGET  = 1050;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES  = 600;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         cfg_we       = 1'b0;
    cfg_index_t                   cfg_index    = CFG_CARROT_DISTANCE;
    logic [CFG_W-1:0]             cfg_data     = '0;
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    logic signed [COORD_BITS-1:0] point_x      = '0;
    logic signed [COORD_BITS-1:0] point_y      = '0;
    logic                         last_point   = 1'b0;
    logic                         empty_marker = 1'b0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    logic signed [COORD_BITS-1:0] carrot_x;
    logic signed [COORD_BITS-1:0] carrot_y;
    logic [CAUSE_W-1:0]           stop_cause;

    carrot_t          expected_carrots[$];
    path_window_t     win;
    logic [CFG_W-1:0] carrot_mm = CARROT_DIST_RESET;
    logic [CFG_W-1:0] bend_q15  = BEND_FACTOR_RESET;
    int               mismatches = 0;
    int               items_sent = 0;
    int               burst_left = 1;
    bit               steady_sender = 1'b0;
    int               hold_requests = 0;

    path_carrot_selector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_point   (last_point),
        .empty_marker (empty_marker),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .carrot_x     (carrot_x),
        .carrot_y     (carrot_y),
        .stop_cause   (stop_cause)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint int_sqrt(input longint v);
        longint root;
        longint trial;
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            trial = root | (64'sd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint seg_dist(input longint ax, ay, bx, by);
        return int_sqrt((bx - ax) * (bx - ax) + (by - ay) * (by - ay));
    endfunction

    function automatic void clear_window();
        win.old_x      = 0;
        win.old_y      = 0;
        win.mid_x      = 0;
        win.mid_y      = 0;
        win.seen       = 0;
        win.seg_len    = 0;
        win.travelled  = 0;
        win.picked     = 1'b0;
        win.pick_x     = 0;
        win.pick_y     = 0;
        win.pick_cause = CAUSE_EMPTY;
    endfunction

    function automatic void shift_window(input longint px, py);
        win.old_x = win.mid_x;
        win.old_y = win.mid_y;
        win.mid_x = px;
        win.mid_y = py;
    endfunction

    // Advances the path window by one point and returns 1 when the point
    // closes the path, with the subtarget that the block should emit.
    function automatic bit predict_carrot(input logic signed [COORD_BITS-1:0] px, py,
                                          input bit last, empty, output carrot_t res);
        int     seen;
        longint pxl;
        longint pyl;
        longint d01;
        longint d12;
        longint d02;
        longint excess;
        seen      = win.seen;
        pxl       = longint'(px);
        pyl       = longint'(py);
        res.x     = px;
        res.y     = py;
        res.cause = CAUSE_END;
        if (empty)
        begin
            res.x     = '0;
            res.y     = '0;
            res.cause = CAUSE_EMPTY;
            clear_window();
            return 1'b1;
        end
        case (seen)
            0: win.seen = 1;
            1:
            begin
                win.mid_x = pxl;
                win.mid_y = pyl;
                win.seen  = 2;
            end
            2:
            begin
                win.seg_len = seg_dist(win.mid_x, win.mid_y, pxl, pyl);
                shift_window(pxl, pyl);
                win.seen = 3;
            end
            default:
            begin
                d01 = win.seg_len;
                d12 = seg_dist(win.mid_x, win.mid_y, pxl, pyl);
                if (!win.picked)
                begin
                    d02    = seg_dist(win.old_x, win.old_y, pxl, pyl);
                    excess = d12 + d01 - d02;
                    if (excess < 0)
                        excess = -excess;
                    win.travelled = win.travelled + d01;
                    if (win.travelled > longint'(RUN_MAX))
                        win.travelled = longint'(RUN_MAX);
                    if (win.travelled > longint'(carrot_mm))
                    begin
                        win.picked     = 1'b1;
                        win.pick_cause = CAUSE_DIST;
                    end
                    else if (excess * 32768 > d01 * longint'(bend_q15))
                    begin
                        win.picked     = 1'b1;
                        win.pick_cause = CAUSE_BEND;
                    end
                    if (win.picked)
                    begin
                        win.pick_x = win.mid_x;
                        win.pick_y = win.mid_y;
                    end
                end
                win.seg_len = d12;
                shift_window(pxl, pyl);
            end
        endcase
        if (!last)
            return 1'b0;
        if (seen < 3)
            res.cause = CAUSE_SHORT;
        else if (win.picked)
        begin
            res.x     = COORD_BITS'(win.pick_x);
            res.y     = COORD_BITS'(win.pick_y);
            res.cause = win.pick_cause;
        end
        clear_window();
        return 1'b1;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_point(input logic signed [COORD_BITS-1:0] x, y,
                              input bit last, empty);
        carrot_t c;
        int      gap;
        in_valid     <= 1'b1;
        point_x      <= x;
        point_y      <= y;
        last_point   <= last;
        empty_marker <= empty;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (predict_carrot(x, y, last, empty, c))
            expected_carrots = {expected_carrots, c};
        if (!steady_sender)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(4, 50);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Lets every outstanding subtarget drain, then waits out any point that
    // may still be in the pipeline.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_carrots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CARROT_DISTANCE: carrot_mm = value;
            CFG_BEND_FACTOR:     bend_q15  = value;
            default:             ;
        endcase
    endtask

    task automatic send_random_path();
        int     n;
        int     cut_at;
        int     scale;
        int     turn_pct;
        longint x;
        longint y;
        longint hx;
        longint hy;
        if ($urandom_range(0, 29) == 0)
        begin
            send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        cut_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : n;
        case ($urandom_range(0, 3))
            0: scale = 40;
            1: scale = 300;
            2: scale = 3000;
            default: scale = 0;
        endcase
        turn_pct = $urandom_range(0, 100);
        x  = longint'($urandom_range(0, 60000)) - 30000;
        y  = longint'($urandom_range(0, 60000)) - 30000;
        hx = longint'($urandom_range(0, 2 * scale)) - scale;
        hy = longint'($urandom_range(0, 2 * scale)) - scale;
        for (int i = 0; i < n; i++)
        begin
            if (i == cut_at)
            begin
                send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)), 1'b1);
                return;
            end
            if (scale == 0)
            begin
                x = longint'(rand_coord());
                y = longint'(rand_coord());
            end
            else
            begin
                if ($urandom_range(1, 100) <= turn_pct)
                begin
                    hx = longint'($urandom_range(0, 2 * scale)) - scale;
                    hy = longint'($urandom_range(0, 2 * scale)) - scale;
                end
                x = clamp_coord(x + hx + longint'($urandom_range(0, scale / 4)) - scale / 8);
                y = clamp_coord(y + hy + longint'($urandom_range(0, scale / 4)) - scale / 8);
            end
            send_point(COORD_BITS'(x), COORD_BITS'(y), i == n - 1, 1'b0);
        end
    endtask

    task automatic test_short_paths();
        send_point(16'sh7fff, -16'sh8000, 1'b0, 1'b1);
        send_point(-16'sh8000, 16'sh7fff, 1'b1, 1'b1);
        send_point(16'sh7fff, -16'sh8000, 1'b1, 1'b0);
        send_point(16'sh0005, 16'sh0007, 1'b0, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b1, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
        send_point(-16'sh8000, 16'sh7fff, 1'b0, 1'b0);
        send_point(16'sh7fff, -16'sh8000, 1'b1, 1'b0);
    endtask

    task automatic test_stop_causes();
        // Straight short steps: nothing fires and the end point stands.
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd100, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd200, 16'sd0, 1'b1, 1'b0);
        // Long straight steps stop on the carrot distance.
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd1000, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd2000, 16'sd0, 1'b1, 1'b0);
        // A hairpin turn on short steps stops on the bend test.
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd100, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd10, 1'b1, 1'b0);
        // Both tests fire; the distance test wins.
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd1000, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd10, 1'b1, 1'b0);
        // An empty marker abandons a path in progress.
        send_point(16'sd300, 16'sd300, 1'b0, 1'b0);
        send_point(16'sd400, 16'sd300, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
    endtask

    task automatic test_config_extremes();
        logic [CFG_W-1:0] dist_set[4] = '{16'd0, 16'd65535, 16'd65535, 16'd0};
        logic [CFG_W-1:0] bend_set[4] = '{16'd0, 16'd65535, 16'd32768, 16'd65535};
        int               stop_at;
        for (int i = 0; i < 4; i++)
        begin
            write_config(CFG_CARROT_DISTANCE, dist_set[i]);
            write_config(CFG_BEND_FACTOR, bend_set[i]);
            stop_at = items_sent + 100;
            while (items_sent < stop_at)
                send_random_path();
        end
    endtask

    task automatic test_output_backpressure();
        settle_block();
        steady_sender = 1'b1;
        hold_requests++;
        for (int i = 0; i < 30; i++)
        begin
            send_point(rand_coord(), rand_coord(), 1'b0, 1'b0);
            send_point(rand_coord(), rand_coord(), 1'b1, 1'b0);
        end
        steady_sender = 1'b0;
    endtask

    task automatic test_random_paths();
        int stop_at;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    write_config(CFG_CARROT_DISTANCE, CARROT_DIST_RESET);
                    write_config(CFG_BEND_FACTOR, BEND_FACTOR_RESET);
                end
                1:
                begin
                    write_config(CFG_CARROT_DISTANCE, CFG_W'($urandom_range(0, 2000)));
                    write_config(CFG_BEND_FACTOR, CFG_W'($urandom_range(0, 32768)));
                end
                default:
                begin
                    write_config(CFG_CARROT_DISTANCE, CFG_W'($urandom));
                    write_config(CFG_BEND_FACTOR, CFG_W'($urandom));
                end
            endcase
            steady_sender = ($urandom_range(0, 3) == 0);
            stop_at = items_sent + 140;
            while (items_sent < stop_at && items_sent < ITEM_TARGET)
                send_random_path();
            steady_sender = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        carrot_t exp_c;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_carrots.size() == 0)
                report_mismatch($sformatf("unexpected result (%0d, %0d) cause %0d",
                                          carrot_x, carrot_y, stop_cause));
            else
            begin
                exp_c = expected_carrots.pop_front();
                if (carrot_x !== exp_c.x)
                    report_mismatch($sformatf("carrot_x %0d, expected %0d",
                                              carrot_x, exp_c.x));
                if (carrot_y !== exp_c.y)
                    report_mismatch($sformatf("carrot_y %0d, expected %0d",
                                              carrot_y, exp_c.y));
                if (stop_cause !== exp_c.cause)
                    report_mismatch($sformatf("stop_cause %0d, expected %0d",
                                              stop_cause, exp_c.cause));
            end
        end
    end

    stall_mode_t stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          hold_left   = 0;
    int          hold_served = 0;
    int          stall_tick  = 0;

    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_requests;
        end
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        stall_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
                default:        out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    initial
    begin
        clear_window();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_paths();
        test_stop_causes();
        test_config_extremes();
        test_output_backpressure();
        test_random_paths();
        settle_block();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_400_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
